// ===== hdl/aso_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_pkg
// Shared types and constants for the stillness and orientation detector.
// ----------------------------------------------------------------------------
package aso_pkg;

  // Field widths
  localparam int ACCEL_BITS = 16;
  localparam int TIME_BITS  = 32;
  localparam int FACE_BITS  = 5;

  // Configuration register widths
  localparam int FMAP_W = 24;
  localparam int THR_W  = 15;
  localparam int GRAV_W = 15;
  localparam int STIME_W = 31;
  localparam int COS_W  = 17;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 3;

  // Derived datapath widths
  localparam int SQ_W   = 2 * ACCEL_BITS - 1;            // one axis squared
  localparam int SUM_W  = 2 * ACCEL_BITS;                // sum of three squares
  localparam int BSUM_W = THR_W + 1;                     // gravity + threshold
  localparam int BND_W  = 2 * BSUM_W;                    // squared bound
  localparam int PROD_W = COS_W + SUM_W;                 // cos^2 * sum
  localparam int Q16    = 16;
  localparam int CMP_W  = (ACCEL_BITS > THR_W) ? ACCEL_BITS : THR_W;
  localparam int SCMP_W = (SUM_W > BND_W) ? SUM_W : BND_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FACE_MAP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_COS  = 3'd4;

  // Register reset values
  localparam logic [FMAP_W-1:0]  FACE_MAP_RST   = 24'h456321;
  localparam logic [THR_W-1:0]   MOTION_THR_RST = 15'd150;
  localparam logic [GRAV_W-1:0]  GRAVITY_RST    = 15'd9800;
  localparam logic [STIME_W-1:0] STILL_TIME_RST = 31'd1000000;
  localparam logic [COS_W-1:0]   SLOPE_COS_RST  = 17'd61147;

  // Result codes
  localparam logic [FACE_BITS-1:0] FACE_MOVING = 5'd0;
  localparam logic [FACE_BITS-1:0] FACE_TILTED = 5'h1F;

  // Motion state
  typedef enum logic [2:0] {
    MS_MOVING  = 3'b001,
    MS_TIMING  = 3'b010,
    MS_STOPPED = 3'b100
  } motion_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // take the input word
    logic mag;      // magnitudes, deltas, bounds
    logic sq;       // per-axis squares, dominant axis
    logic sum;      // sum of squares
    logic tilt;     // tilt product, stillness, elapsed time
    logic commit;   // update state, load result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stall;    // a result is due but the output slot is occupied
  } status_t;

endpackage

// ===== hdl/accel_stillness_orientation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_stillness_orientation
// Stillness and resting-face detector for a three-axis accelerometer.
// ----------------------------------------------------------------------------
// Each sample word occupies the block for the idle state in which it is
// accepted and five sequencer phases (magnitudes and deltas, squares, sum,
// tilt product, decision), set by the controller stepping one sample at a
// time through the shared datapath. A result, when there is one, is loaded
// into the output register on leaving the decision phase, and the next word
// is accepted only once the block is back in idle, so a word cannot be taken
// before the last one is through. A result waiting in the output register
// does not block acceptance, but a decision that yields a result holds while
// that register stays occupied. Results are 0 for a moving sample, one face
// value when stillness has lasted still_time_us, or -1 when the tilt is too
// large. Configuration writes are always accepted and must be issued while
// the block is idle.
module accel_stillness_orientation (
  input  logic                            clk,
  input  logic                            rst,
  // sample stream; tdata from bit 0: accel_x, accel_y, accel_z, sample_time_us
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [79:0]                     s_axis_tdata,
  // result stream; tdata from bit 0: face_number, zero padding
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aso_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aso_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import aso_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic signed [FACE_BITS-1:0] face_number;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {(8 - FACE_BITS)'(0), face_number};

  aso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  aso_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .accel_x        (s_axis_tdata[15:0]),
    .accel_y        (s_axis_tdata[31:16]),
    .accel_z        (s_axis_tdata[47:32]),
    .sample_time_us (s_axis_tdata[79:48]),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .face_number    (face_number)
  );

endmodule

// ===== hdl/aso_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_ctrl
// Sequencer: steps one sample through the datapath phases.
// ----------------------------------------------------------------------------
module aso_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  aso_pkg::status_t status,
  output aso_pkg::cmd_t    cmd
);
  import aso_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MAG    = 6'b000010,
    ST_SQ     = 6'b000100,
    ST_SUM    = 6'b001000,
    ST_TILT   = 6'b010000,
    ST_DECIDE = 6'b100000
  } state_t;

  state_t state, state_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MAG;
      ST_MAG:    state_next = ST_SQ;
      ST_SQ:     state_next = ST_SUM;
      ST_SUM:    state_next = ST_TILT;
      ST_TILT:   state_next = ST_DECIDE;
      ST_DECIDE: if (!status.stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands
  assign in_ready   = (state == ST_IDLE);
  assign cmd.load   = in_ready && in_valid;
  assign cmd.mag    = (state == ST_MAG);
  assign cmd.sq     = (state == ST_SQ);
  assign cmd.sum    = (state == ST_SUM);
  assign cmd.tilt   = (state == ST_TILT);
  assign cmd.commit = (state == ST_DECIDE) && !status.stall;

endmodule

// ===== hdl/aso_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_datapath
// Registers, arithmetic, motion state and output slot of the detector.
// ----------------------------------------------------------------------------
module aso_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  aso_pkg::cmd_t                         cmd,
  output aso_pkg::status_t                      status,
  // sample
  input  logic signed [aso_pkg::ACCEL_BITS-1:0] accel_x,
  input  logic signed [aso_pkg::ACCEL_BITS-1:0] accel_y,
  input  logic signed [aso_pkg::ACCEL_BITS-1:0] accel_z,
  input  logic        [aso_pkg::TIME_BITS-1:0]  sample_time_us,
  // configuration
  input  logic                                  cfg_we,
  input  logic        [aso_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [aso_pkg::CFG_DATA_W-1:0] cfg_data,
  // result
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [aso_pkg::FACE_BITS-1:0]  face_number
);
  import aso_pkg::*;

  localparam int A = ACCEL_BITS;

  // Configuration registers
  logic [FMAP_W-1:0]  face_map;
  logic [THR_W-1:0]   motion_threshold;
  logic [GRAV_W-1:0]  gravity_level;
  logic [STIME_W-1:0] still_time_us;
  logic [COS_W-1:0]   slope_cos_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_map         <= FACE_MAP_RST;
      motion_threshold <= MOTION_THR_RST;
      gravity_level    <= GRAVITY_RST;
      still_time_us    <= STILL_TIME_RST;
      slope_cos_sq     <= SLOPE_COS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FACE_MAP:   face_map         <= cfg_data[FMAP_W-1:0];
        REG_MOTION_THR: motion_threshold <= cfg_data[THR_W-1:0];
        REG_GRAVITY:    gravity_level    <= cfg_data[GRAV_W-1:0];
        REG_STILL_TIME: still_time_us    <= cfg_data[STIME_W-1:0];
        REG_SLOPE_COS:  slope_cos_sq     <= cfg_data[COS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture
  logic signed [A-1:0]         acc [3];
  logic        [TIME_BITS-1:0] now;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc[0] <= accel_x;
      acc[1] <= accel_y;
      acc[2] <= accel_z;
      now    <= sample_time_us;
    end
  end

  // Persistent state
  logic signed [A-1:0]         prev [3];
  logic        [TIME_BITS-1:0] still_start_time;
  motion_t                     motion_state;

  // Phase 1: magnitudes, per-axis deltas, magnitude bounds
  logic [A-1:0]      mag_c  [3];
  logic [2:0]        delta_ok_c;
  logic [A-1:0]      mag    [3];
  logic [2:0]        delta_ok;
  logic [2:0]        neg;
  logic [BSUM_W-1:0] hi_sum_c;
  logic [BND_W-1:0]  hi_sq;
  logic [BND_W-1:0]  lo_sq;
  logic              lo_en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [A:0] d;
      logic        [A-1:0] dmag;
      mag_c[i] = acc[i][A-1] ? A'(~acc[i] + 1'b1) : acc[i];
      d        = {acc[i][A-1], acc[i]} - {prev[i][A-1], prev[i]};
      dmag     = d[A] ? A'(~d + 1'b1) : d[A-1:0];
      delta_ok_c[i] = CMP_W'(dmag) < CMP_W'(motion_threshold);
    end
    hi_sum_c = BSUM_W'(gravity_level) + BSUM_W'(motion_threshold);
  end

  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= mag_c[i];
        neg[i] <= acc[i][A-1];
      end
      delta_ok <= delta_ok_c;
      hi_sq    <= hi_sum_c * hi_sum_c;
      lo_en    <= gravity_level > motion_threshold;
      lo_sq    <= BND_W'(BSUM_W'(gravity_level - motion_threshold)
                  * BSUM_W'(gravity_level - motion_threshold));
    end
  end

  // Phase 2: per-axis squares and dominant axis (lowest index on ties)
  logic [SQ_W-1:0] sq [3];
  logic [1:0]      dom_c;
  logic [1:0]      dom;
  logic            dom_neg;

  always_comb begin
    dom_c = 2'd0;
    if (mag[0] < mag[1]) dom_c = 2'd1;
    if (mag[dom_c] < mag[2]) dom_c = 2'd2;
  end

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SQ_W'(mag[i] * mag[i]);
      end
      dom     <= dom_c;
      dom_neg <= neg[dom_c];
    end
  end

  // Phase 3: sum of squares
  logic [SUM_W-1:0] s_sum;
  logic [SQ_W-1:0]  dom_sq;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      s_sum  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      dom_sq <= sq[dom];
    end
  end

  // Phase 4: tilt product, stillness, elapsed time
  logic [PROD_W-1:0]    tilt_prod;
  logic                 still;
  logic                 time_ok;
  logic [TIME_BITS-1:0] elapsed_c;

  assign elapsed_c = now - still_start_time;

  always_ff @(posedge clk) begin
    if (cmd.tilt) begin
      tilt_prod <= PROD_W'(slope_cos_sq) * PROD_W'(s_sum);
      still     <= (&delta_ok)
                   && (SCMP_W'(s_sum) < SCMP_W'(hi_sq))
                   && !(lo_en && (SCMP_W'(s_sum) <= SCMP_W'(lo_sq)));
      time_ok   <= elapsed_c >= TIME_BITS'(still_time_us);
    end
  end

  // Decision
  logic                 tilt_ok;
  logic [2:0]           slot;
  logic [3:0]           nibble;
  logic                 need_res;
  logic [FACE_BITS-1:0] res;

  always_comb begin
    tilt_ok  = (s_sum != '0)
               && (PROD_W'({dom_sq, Q16'(0)}) >= tilt_prod);
    slot     = dom_neg ? {1'b0, dom} : ({1'b0, dom} + 3'd3);
    nibble   = face_map[{slot, 2'b00} +: 4];
    need_res = !still || ((motion_state == MS_TIMING) && time_ok);
    if (!still) begin
      res = FACE_MOVING;
    end else if (tilt_ok) begin
      res = {1'b0, nibble};
    end else begin
      res = FACE_TILTED;
    end
  end

  assign status.stall = need_res && out_valid && !out_ready;

  // State update on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_state <= MS_MOVING;
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < 3; i++) begin
        prev[i] <= acc[i];
      end
      if (!still) begin
        motion_state <= MS_MOVING;
      end else begin
        case (motion_state)
          MS_MOVING:  motion_state <= MS_TIMING;
          MS_TIMING:  if (time_ok) motion_state <= MS_STOPPED;
          MS_STOPPED: motion_state <= MS_STOPPED;
          default:    motion_state <= MS_STOPPED;
        endcase
      end
    end
  end

  // Start time is written on entry to timing
  always_ff @(posedge clk) begin
    if (cmd.commit && still && (motion_state == MS_MOVING)) begin
      still_start_time <= now;
    end
  end

  // Output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && need_res) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && need_res) begin
      face_number <= res;
    end
  end

endmodule
